// ===== src/llt_pkg.sv =====
// Shared constants, codes and record types of the layout language tokenizer.
`default_nettype none
package llt_pkg;

   localparam int OFFSET_WIDTH = 24;
   localparam int LINE_WIDTH = 20;
   localparam int FRACTION_BITS = 16;
   localparam int MAX_COLOR_DIGITS = 8;

   localparam int INT_BITS = 39 - FRACTION_BITS;
   localparam int FRAC_DIGITS = 5;
   localparam int FRAC_ACC_BITS = 17;
   localparam int DIGIT_CNT_BITS = 3;
   localparam int NUMBER_WIDTH = 40;
   localparam int MAX_RESULTS = 3;
   localparam int FIFO_DEPTH = 4;

   localparam logic [4:0] KIND_EOF = 5'd0;
   localparam logic [4:0] KIND_IDENT = 5'd1;
   localparam logic [4:0] KIND_NUMBER = 5'd5;
   localparam logic [4:0] KIND_STRING = 5'd6;
   localparam logic [4:0] KIND_COLOR = 5'd7;
   localparam logic [4:0] KIND_LBRACE = 5'd8;
   localparam logic [4:0] KIND_RBRACE = 5'd9;
   localparam logic [4:0] KIND_LPAREN = 5'd10;
   localparam logic [4:0] KIND_RPAREN = 5'd11;
   localparam logic [4:0] KIND_COLON = 5'd12;
   localparam logic [4:0] KIND_COMMA = 5'd13;
   localparam logic [4:0] KIND_DOT = 5'd14;
   localparam logic [4:0] KIND_PERCENT = 5'd15;
   localparam logic [4:0] KIND_ERROR = 5'd16;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
   localparam logic [1:0] ERR_BAD_COLOR = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_STRING, MODE_COLOR,
      MODE_LINE, MODE_BLOCK, MODE_STAR, MODE_SLASH, MODE_MINUS, MODE_POINT
   } mode_type;

   // One token on its way out; the number is still in decimal parts.
   typedef struct packed {
      logic [4:0]                kind;
      logic [OFFSET_WIDTH-1:0]   start;
      logic [OFFSET_WIDTH-1:0]   len;
      logic [LINE_WIDTH-1:0]     line;
      logic [LINE_WIDTH-1:0]     col;
      logic                      neg;
      logic [INT_BITS-1:0]       int_part;
      logic [FRAC_ACC_BITS-1:0]  frac;
      logic [DIGIT_CNT_BITS-1:0] frac_digits;
      logic [7:0]                red;
      logic [7:0]                green;
      logic [7:0]                blue;
      logic [7:0]                alpha;
      logic [1:0]                err;
      logic                      last;
   } token_type;

   typedef struct packed {
      logic [1:0]                      count;
      token_type [MAX_RESULTS-1:0]     slot;
   } push_type;

endpackage
`default_nettype wire

// ===== src/llt_if.sv =====
// Request and response channel interfaces of the tokenizer.
`default_nettype none
interface llt_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] source_byte;
   modport source (output valid, output op, output source_byte, input ready);
   modport sink (input valid, input op, input source_byte, output ready);
endinterface

interface llt_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         token_kind;
   logic [23:0]        start_offset;
   logic [23:0]        lexeme_length;
   logic [19:0]        line_number;
   logic [19:0]        column_number;
   logic signed [39:0] number_value;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   logic [7:0]         alpha;
   logic [1:0]         error_kind;
   logic               last;
   modport source (output valid, output token_kind, output start_offset, output lexeme_length,
                   output line_number, output column_number, output number_value,
                   output red, output green, output blue, output alpha, output error_kind,
                   output last, input ready);
   modport sink (input valid, input token_kind, input start_offset, input lexeme_length,
                 input line_number, input column_number, input number_value,
                 input red, input green, input blue, input alpha, input error_kind,
                 input last, output ready);
endinterface
`default_nettype wire

// ===== src/llt_core.sv =====
// Lexer state machine: consumes one byte per transaction and emits up to three tokens.
`default_nettype none
module llt_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              in_op,
   input  logic [7:0]        in_byte,
   output llt_pkg::push_type push
);
   import llt_pkg::*;

   typedef struct packed {
      logic [OFFSET_WIDTH-1:0] offset;
      logic [LINE_WIDTH-1:0]   line;
      logic [LINE_WIDTH-1:0]   col;
   } pos_type;

   localparam pos_type POS_START = '{offset: '0, line: LINE_WIDTH'(1), col: LINE_WIDTH'(1)};
   localparam int IACC_W = INT_BITS + 4;
   localparam logic [IACC_W-1:0] INT_MAX = IACC_W'({INT_BITS{1'b1}});

   mode_type                  mode_ff, mode_in;
   pos_type                   pos_ff, pos_in, tok_ff, tok_in, eof_pos;
   logic [INT_BITS-1:0]       iacc_ff, iacc_in;
   logic [FRAC_ACC_BITS-1:0]  facc_ff, facc_in;
   logic [DIGIT_CNT_BITS-1:0] fcnt_ff, fcnt_in;
   logic                      neg_ff, neg_in;
   logic [3:0]                hcnt_ff, hcnt_in;
   logic [1:0]                kwm_ff, kwm_in;
   logic                      esc_ff, esc_in;
   logic [3:0]                hex_ff [MAX_COLOR_DIGITS];
   logic                      hex_we;
   logic [2:0]                hex_idx;
   logic [4:0]                hex_nib;
   logic [1:0]                n;
   token_type [MAX_RESULTS-1:0] slot;
   logic                      do_idle;
   logic [7:0]                c;
   logic [IACC_W-1:0]         int_next;
   logic [OFFSET_WIDTH-1:0]   kw_pos;
   logic [4:0]                punct;

   function automatic pos_type step_pos(pos_type p, logic [7:0] ch);
      pos_type q;
      q = p;
      q.offset = p.offset + 1'b1;
      if (ch == 8'h0A) begin
         if (p.line != '1) q.line = p.line + 1'b1;
         q.col = LINE_WIDTH'(1);
      end else if (p.col != '1) begin
         q.col = p.col + 1'b1;
      end
      return q;
   endfunction

   function automatic logic is_digit(logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] ch);
      return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") || ch == "_";
   endfunction

   // Bit 4 flags a valid hex digit.
   function automatic logic [4:0] hex_value(logic [7:0] ch);
      logic [4:0] v;
      v = '0;
      if (ch >= "0" && ch <= "9") v = {1'b1, ch[3:0]};
      else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F"))
         v = {1'b1, ch[3:0] + 4'd9};
      return v;
   endfunction

   function automatic logic [2:0] kw_len(logic [1:0] k);
      return (k == 2'd2) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] p);
      logic [7:0] ch;
      ch = 8'h00;
      case (k)
         2'd1: case (p)
            3'd0: ch = "t";
            3'd1: ch = "r";
            3'd2: ch = "u";
            3'd3: ch = "e";
            default: ch = 8'h00;
         endcase
         2'd2: case (p)
            3'd0: ch = "f";
            3'd1: ch = "a";
            3'd2: ch = "l";
            3'd3: ch = "s";
            3'd4: ch = "e";
            default: ch = 8'h00;
         endcase
         2'd3: case (p)
            3'd0: ch = "n";
            3'd1: ch = "u";
            3'd2: ch = "l";
            3'd3: ch = "l";
            default: ch = 8'h00;
         endcase
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic token_type blank(logic [4:0] kind, pos_type at, logic [OFFSET_WIDTH-1:0] len,
                                       logic [1:0] err);
      token_type t;
      t = '0;
      t.kind = kind;
      t.start = at.offset;
      t.len = len;
      t.line = at.line;
      t.col = at.col;
      t.err = err;
      return t;
   endfunction

   // The finishing helpers only ever see the state left by the previous byte.
   function automatic token_type mk_ident();
      token_type t;
      logic [OFFSET_WIDTH-1:0] len;
      len = pos_ff.offset - tok_ff.offset;
      t = blank(KIND_IDENT, tok_ff, len, ERR_NONE);
      if (kwm_ff != 2'd0 && len == OFFSET_WIDTH'(kw_len(kwm_ff)))
         t.kind = KIND_IDENT + {3'd0, kwm_ff};
      return t;
   endfunction

   function automatic token_type mk_number();
      token_type t;
      t = blank(KIND_NUMBER, tok_ff, pos_ff.offset - tok_ff.offset, ERR_NONE);
      t.neg = neg_ff;
      t.int_part = iacc_ff;
      t.frac = facc_ff;
      t.frac_digits = fcnt_ff;
      return t;
   endfunction

   function automatic token_type mk_color();
      token_type t;
      t = blank(KIND_COLOR, tok_ff, pos_ff.offset - tok_ff.offset, ERR_NONE);
      t.alpha = 8'hFF;
      case (hcnt_ff)
         4'd3, 4'd4: begin
            t.red = {hex_ff[0], hex_ff[0]};
            t.green = {hex_ff[1], hex_ff[1]};
            t.blue = {hex_ff[2], hex_ff[2]};
            if (hcnt_ff == 4'd4) t.alpha = {hex_ff[3], hex_ff[3]};
         end
         4'd6, 4'd8: begin
            t.red = {hex_ff[0], hex_ff[1]};
            t.green = {hex_ff[2], hex_ff[3]};
            t.blue = {hex_ff[4], hex_ff[5]};
            if (hcnt_ff == 4'd8) t.alpha = {hex_ff[6], hex_ff[7]};
         end
         default: t = blank(KIND_ERROR, tok_ff, '0, ERR_BAD_COLOR);
      endcase
      return t;
   endfunction

   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      tok_in = tok_ff;
      iacc_in = iacc_ff;
      facc_in = facc_ff;
      fcnt_in = fcnt_ff;
      neg_in = neg_ff;
      hcnt_in = hcnt_ff;
      kwm_in = kwm_ff;
      esc_in = esc_ff;
      hex_we = 1'b0;
      hex_idx = hcnt_ff[2:0];
      hex_nib = hex_value(in_byte);
      n = 2'd0;
      slot = '0;
      do_idle = 1'b0;
      c = in_byte;
      int_next = IACC_W'(iacc_ff) * IACC_W'(10) + IACC_W'(in_byte[3:0]);
      kw_pos = pos_ff.offset - tok_ff.offset;
      punct = '0;
      eof_pos = pos_ff;

      if (accept && in_op) begin
         case (mode_ff)
            MODE_IDENT: begin slot[n] = mk_ident(); n = n + 1'b1; end
            MODE_INT, MODE_FRAC: begin slot[n] = mk_number(); n = n + 1'b1; end
            MODE_POINT: begin
               slot[n] = mk_number(); n = n + 1'b1;
               slot[n] = blank(KIND_DOT, pos_ff, OFFSET_WIDTH'(1), ERR_NONE); n = n + 1'b1;
               eof_pos = step_pos(pos_ff, ".");
            end
            MODE_STRING: begin
               // The error points back at the opening quote.
               slot[n] = blank(KIND_ERROR, tok_ff, '0, ERR_UNTERMINATED);
               slot[n].start = tok_ff.offset - 1'b1;
               n = n + 1'b1;
            end
            MODE_COLOR: begin slot[n] = mk_color(); n = n + 1'b1; end
            MODE_SLASH, MODE_MINUS: begin
               slot[n] = blank(KIND_ERROR, pos_ff, '0, ERR_UNEXPECTED); n = n + 1'b1;
               eof_pos = step_pos(pos_ff, "-");
            end
            default: ;
         endcase
         slot[n] = blank(KIND_EOF, eof_pos, '0, ERR_NONE);
         n = n + 1'b1;
         mode_in = MODE_IDLE;
         pos_in = POS_START;
         tok_in = POS_START;
         iacc_in = '0;
         facc_in = '0;
         fcnt_in = '0;
         neg_in = 1'b0;
         hcnt_in = '0;
         kwm_in = '0;
         esc_in = 1'b0;
      end else if (accept) begin
         case (mode_ff)
            MODE_IDENT: begin
               if (!(is_alpha(c) || is_digit(c) || c == "-")) begin
                  slot[n] = mk_ident(); n = n + 1'b1;
                  do_idle = 1'b1;
               end else begin
                  if (!(kwm_ff != 2'd0 && kw_pos < OFFSET_WIDTH'(kw_len(kwm_ff))
                        && c == kw_char(kwm_ff, kw_pos[2:0])))
                     kwm_in = 2'd0;
                  pos_in = step_pos(pos_ff, c);
               end
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  iacc_in = (int_next > INT_MAX) ? INT_MAX[INT_BITS-1:0] : int_next[INT_BITS-1:0];
                  pos_in = step_pos(pos_ff, c);
               end else if (c == ".") begin
                  mode_in = MODE_POINT;
               end else begin
                  slot[n] = mk_number(); n = n + 1'b1;
                  do_idle = 1'b1;
               end
            end
            MODE_POINT: begin
               if (is_digit(c)) begin
                  pos_in = step_pos(step_pos(pos_ff, "."), c);
                  facc_in = FRAC_ACC_BITS'(c[3:0]);
                  fcnt_in = DIGIT_CNT_BITS'(1);
                  mode_in = MODE_FRAC;
               end else begin
                  slot[n] = mk_number(); n = n + 1'b1;
                  slot[n] = blank(KIND_DOT, pos_ff, OFFSET_WIDTH'(1), ERR_NONE); n = n + 1'b1;
                  pos_in = step_pos(pos_ff, ".");
                  do_idle = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (!is_digit(c)) begin
                  slot[n] = mk_number(); n = n + 1'b1;
                  do_idle = 1'b1;
               end else begin
                  if (fcnt_ff < DIGIT_CNT_BITS'(FRAC_DIGITS)) begin
                     facc_in = FRAC_ACC_BITS'(facc_ff * FRAC_ACC_BITS'(10))
                               + FRAC_ACC_BITS'(c[3:0]);
                     fcnt_in = fcnt_ff + 1'b1;
                  end
                  pos_in = step_pos(pos_ff, c);
               end
            end
            MODE_STRING: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (c == "\"") begin
                  slot[n] = blank(KIND_STRING, tok_ff, pos_ff.offset - tok_ff.offset, ERR_NONE);
                  n = n + 1'b1;
                  mode_in = MODE_IDLE;
               end else if (c == "\\") begin
                  esc_in = 1'b1;
               end
               pos_in = step_pos(pos_ff, c);
            end
            MODE_COLOR: begin
               if (hex_nib[4] && hcnt_ff < 4'(MAX_COLOR_DIGITS)) begin
                  hex_we = 1'b1;
                  hcnt_in = hcnt_ff + 1'b1;
                  pos_in = step_pos(pos_ff, c);
               end else begin
                  slot[n] = mk_color(); n = n + 1'b1;
                  do_idle = 1'b1;
               end
            end
            MODE_LINE: begin
               if (c == 8'h0A) mode_in = MODE_IDLE;
               pos_in = step_pos(pos_ff, c);
            end
            MODE_BLOCK: begin
               if (c == "*") mode_in = MODE_STAR;
               pos_in = step_pos(pos_ff, c);
            end
            MODE_STAR: begin
               if (c == "/") mode_in = MODE_IDLE;
               else if (c != "*") mode_in = MODE_BLOCK;
               pos_in = step_pos(pos_ff, c);
            end
            MODE_SLASH: begin
               if (c == "/" || c == "*") begin
                  pos_in = step_pos(step_pos(pos_ff, "/"), c);
                  mode_in = (c == "/") ? MODE_LINE : MODE_BLOCK;
               end else begin
                  slot[n] = blank(KIND_ERROR, pos_ff, '0, ERR_UNEXPECTED); n = n + 1'b1;
                  pos_in = step_pos(pos_ff, "/");
                  do_idle = 1'b1;
               end
            end
            MODE_MINUS: begin
               if (is_digit(c)) begin
                  tok_in = pos_ff;
                  pos_in = step_pos(step_pos(pos_ff, "-"), c);
                  neg_in = 1'b1;
                  iacc_in = INT_BITS'(c[3:0]);
                  facc_in = '0;
                  fcnt_in = '0;
                  mode_in = MODE_INT;
               end else begin
                  slot[n] = blank(KIND_ERROR, pos_ff, '0, ERR_UNEXPECTED); n = n + 1'b1;
                  pos_in = step_pos(pos_ff, "-");
                  do_idle = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         // Between tokens: the byte either is skipped or opens a new token.
         if (do_idle) begin
            mode_in = MODE_IDLE;
            if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
               pos_in = step_pos(pos_in, c);
            end else begin
               tok_in = pos_in;
               if (is_alpha(c)) begin
                  kwm_in = (c == "t") ? 2'd1 : (c == "f") ? 2'd2 : (c == "n") ? 2'd3 : 2'd0;
                  pos_in = step_pos(pos_in, c);
                  mode_in = MODE_IDENT;
               end else if (is_digit(c)) begin
                  pos_in = step_pos(pos_in, c);
                  neg_in = 1'b0;
                  iacc_in = INT_BITS'(c[3:0]);
                  facc_in = '0;
                  fcnt_in = '0;
                  mode_in = MODE_INT;
               end else if (c == "-") begin
                  mode_in = MODE_MINUS;
               end else if (c == "/") begin
                  mode_in = MODE_SLASH;
               end else if (c == "\"") begin
                  pos_in = step_pos(pos_in, c);
                  tok_in.offset = pos_in.offset;
                  esc_in = 1'b0;
                  mode_in = MODE_STRING;
               end else if (c == "#") begin
                  pos_in = step_pos(pos_in, c);
                  hcnt_in = '0;
                  mode_in = MODE_COLOR;
               end else begin
                  case (c)
                     "{": punct = KIND_LBRACE;
                     "}": punct = KIND_RBRACE;
                     "(": punct = KIND_LPAREN;
                     ")": punct = KIND_RPAREN;
                     ":": punct = KIND_COLON;
                     ",": punct = KIND_COMMA;
                     ".": punct = KIND_DOT;
                     "%": punct = KIND_PERCENT;
                     default: punct = '0;
                  endcase
                  if (punct != '0) slot[n] = blank(punct, tok_in, OFFSET_WIDTH'(1), ERR_NONE);
                  else slot[n] = blank(KIND_ERROR, tok_in, '0, ERR_UNEXPECTED);
                  n = n + 1'b1;
                  pos_in = step_pos(pos_in, c);
               end
            end
         end
      end

      if (n != 2'd0) slot[n - 1'b1].last = 1'b1;
      push.count = n;
      push.slot = slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff <= POS_START;
         tok_ff <= POS_START;
         iacc_ff <= '0;
         facc_ff <= '0;
         fcnt_ff <= '0;
         neg_ff <= 1'b0;
         hcnt_ff <= '0;
         kwm_ff <= '0;
         esc_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         tok_ff <= tok_in;
         iacc_ff <= iacc_in;
         facc_ff <= facc_in;
         fcnt_ff <= fcnt_in;
         neg_ff <= neg_in;
         hcnt_ff <= hcnt_in;
         kwm_ff <= kwm_in;
         esc_ff <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hex_we) hex_ff[hex_idx] <= hex_nib[3:0];
   end

`ifndef SYNTHESIS
   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && in_op |=> mode_ff == MODE_IDLE && pos_ff.offset == '0)
      else $error("lexer did not restart after end of source");
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      accept && in_op |-> push.count != 2'd0 && push.slot[push.count - 1'b1].kind == KIND_EOF)
      else $error("end of source did not end with an eof token");
   a_idle_no_push: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.count == 2'd0)
      else $error("tokens pushed without a transaction");
`endif
endmodule
`default_nettype wire

// ===== src/llt_fifo.sv =====
// Small token queue that takes up to three tokens a cycle and gives one.
`default_nettype none
module llt_fifo (
   input  logic               clock,
   input  logic               reset,
   input  llt_pkg::push_type  push,
   input  logic               pop,
   output llt_pkg::token_type head,
   output logic               head_valid,
   output logic               room
);
   import llt_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   token_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign head = mem_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign room = count_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS);
   assign do_pop = pop && head_valid;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
   assign count_in = count_ff + CNT_W'(push.count) - CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push.count) mem_ff[wr_ptr_ff + PTR_W'(i)] <= push.slot[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("token queue overflow");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(push.count) <= CNT_W'(FIFO_DEPTH) - count_ff)
      else $error("tokens pushed without room");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(count_ff) == wr_ptr_ff - rd_ptr_ff)
      else $error("queue pointers disagree with fill count");
`endif
endmodule
`default_nettype wire

// ===== src/llt_numconv.sv =====
// Output pipeline that turns the decimal fraction into fixed point and drives the response.
`default_nettype none
module llt_numconv (
   input  logic               clock,
   input  logic               reset,
   input  llt_pkg::token_type head,
   input  logic               head_valid,
   output logic               pop,
   llt_rsp_if.source          rsp_bus
);
   import llt_pkg::*;

   // round(f5 * 2^FB / 100000) == floor((f5 * 2^(FB-5) + 1562) / 3125).
   localparam int PRE = FRACTION_BITS - 5;
   localparam int YW = PRE + FRAC_ACC_BITS;
   localparam int YH = YW / 2;
   localparam int MW = YW - 11;
   localparam int QW = FRACTION_BITS + 1;
   localparam int PHW = YW - YH + MW;
   localparam int PLW = YH + MW;
   localparam int SW = YW + MW + 1;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << YW) / 64'd3125);
   localparam logic [NUMBER_WIDTH-1:0] MAG_MAX = NUMBER_WIDTH'({(NUMBER_WIDTH-1){1'b1}});

   logic            advance;
   logic            v1_ff, v2_ff, v3_ff, v4_ff;
   token_type       t1_ff, t2_ff, t3_ff, t4_ff;
   logic [YW-1:0]   y1_ff, y1_in, y2_ff, y3_ff;
   logic [PHW-1:0]  ph_ff, ph_in;
   logic [PLW-1:0]  pl_ff, pl_in;
   logic [QW-1:0]   q0_ff, q0_in, q;
   logic [SW-1:0]   sum;
   logic [FRAC_ACC_BITS-1:0] scale, f5;
   logic [2*FRAC_ACC_BITS-1:0] f5_full;
   logic [YW-1:0]   rem;
   logic [NUMBER_WIDTH-1:0] mag, mag_ff, mag_in;

   function automatic logic [FRAC_ACC_BITS-1:0] pow10(logic [DIGIT_CNT_BITS-1:0] digits);
      logic [FRAC_ACC_BITS-1:0] p;
      case (digits)
         3'd1: p = FRAC_ACC_BITS'(10000);
         3'd2: p = FRAC_ACC_BITS'(1000);
         3'd3: p = FRAC_ACC_BITS'(100);
         3'd4: p = FRAC_ACC_BITS'(10);
         3'd5: p = FRAC_ACC_BITS'(1);
         default: p = '0;
      endcase
      return p;
   endfunction

   assign advance = !v4_ff || rsp_bus.ready;
   assign pop = advance && head_valid;

   // Stage 1: scale the kept digits to five places.
   always_comb begin
      scale = pow10(head.frac_digits);
      f5_full = (2*FRAC_ACC_BITS)'(head.frac) * (2*FRAC_ACC_BITS)'(scale);
      f5 = f5_full[FRAC_ACC_BITS-1:0];
      y1_in = {f5, {PRE{1'b0}}} + YW'(1562);
   end

   // Stage 2: reciprocal multiply split into two partial products.
   assign ph_in = PHW'(y1_ff[YW-1:YH]) * PHW'(RECIP);
   assign pl_in = PLW'(y1_ff[YH-1:0]) * PLW'(RECIP);

   // Stage 3: combine; the estimate is exact or one short.
   assign sum = {ph_ff, {YH{1'b0}}} + SW'(pl_ff);
   assign q0_in = sum[YW +: QW];

   // Stage 4: one correction step, then sign and saturation.
   always_comb begin
      rem = y3_ff - YW'(YW'(q0_ff) * YW'(3125));
      q = q0_ff + QW'(rem >= YW'(3125));
      mag = NUMBER_WIDTH'({t3_ff.int_part, {FRACTION_BITS{1'b0}}}) + NUMBER_WIDTH'(q);
      if (mag > MAG_MAX) mag = MAG_MAX;
      mag_in = t3_ff.neg ? (~mag + 1'b1) : mag;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff <= head;
         y1_ff <= y1_in;
         t2_ff <= t1_ff;
         y2_ff <= y1_ff;
         ph_ff <= ph_in;
         pl_ff <= pl_in;
         t3_ff <= t2_ff;
         y3_ff <= y2_ff;
         q0_ff <= q0_in;
         t4_ff <= t3_ff;
         mag_ff <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= head_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign rsp_bus.valid = v4_ff;
   assign rsp_bus.token_kind = t4_ff.kind;
   assign rsp_bus.start_offset = t4_ff.start;
   assign rsp_bus.lexeme_length = t4_ff.len;
   assign rsp_bus.line_number = t4_ff.line;
   assign rsp_bus.column_number = t4_ff.col;
   assign rsp_bus.number_value = mag_ff;
   assign rsp_bus.red = t4_ff.red;
   assign rsp_bus.green = t4_ff.green;
   assign rsp_bus.blue = t4_ff.blue;
   assign rsp_bus.alpha = t4_ff.alpha;
   assign rsp_bus.error_kind = t4_ff.err;
   assign rsp_bus.last = t4_ff.last;
endmodule
`default_nettype wire

// ===== src/layout_language_tokenizer.sv =====
// Top level of the streaming layout language tokenizer.
// The tokenizer takes one source byte or end-of-source marker per cycle while
// the queue has room and updates its lexer state in that same cycle; the tokens
// a transaction causes (up to three) enter a four-entry queue and leave through
// a four-stage pipeline that converts numbers to fixed point, one token per
// cycle while the response side is not stalled. A new transaction is taken
// while at most one token waits in the queue, so input runs at one byte per
// cycle as long as bytes average at most one token each and the receiver keeps
// up; bytes that finish two or three tokens at once hold the input back while
// the queue drains. A token reaches the response side after every pipeline stage.
`default_nettype none
module layout_language_tokenizer (
   input logic        clock,
   input logic        reset,
   llt_req_if.sink    req_bus,
   llt_rsp_if.source  rsp_bus
);
   import llt_pkg::*;

   push_type  push;
   token_type head;
   logic      head_valid;
   logic      pop;
   logic      room;
   logic      accept;

   assign req_bus.ready = room;
   assign accept = req_bus.valid && room;

   llt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_op   (req_bus.op),
      .in_byte (req_bus.source_byte),
      .push    (push)
   );

   llt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .room       (room)
   );

   llt_numconv u_numconv (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench of the layout language tokenizer.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import llt_pkg::*;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
   } src_item_type;

   typedef struct packed {
      logic [4:0]         kind;
      logic [23:0]        start;
      logic [23:0]        len;
      logic [19:0]        line;
      logic [19:0]        col;
      logic signed [39:0] num;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [1:0]         err;
      logic               last;
   } rsp_item_type;

   localparam int IDLE_LIMIT = 4000;
   localparam logic [19:0] LINE_SAT = '1;
   localparam longint unsigned MAG_SAT = (64'd1 << 39) - 1;
   localparam longint unsigned INT_SAT = (64'd1 << INT_BITS) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   llt_req_if req_bus();
   llt_rsp_if rsp_bus();

   layout_language_tokenizer uut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always #4 clock = ~clock;

   src_item_type source_q[$];
   rsp_item_type token_q[$];
   int        n_sent = 0;
   int        mismatches = 0;
   int        unexpected_tokens = 0;
   int        idle_cycles = 0;
   int        send_idle_pct = 28;
   int        recv_idle_pct = 88;
   int        hold_cycles = 0;
   bit        hold_done = 0;
   bit        req_taken = 0;

   // Lexer state of the predictor.
   mode_type    mode;
   logic [23:0] ofs, tok_start;
   logic [19:0] cur_line, cur_col, tok_line, tok_col;
   longint unsigned int_acc, frac_acc;
   int          frac_cnt;
   bit          neg, esc;
   logic [3:0]  hexd[8];
   int          hexn, kw;
   rsp_item_type step_q[$];

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int hex_value(logic [7:0] c);
      if (is_digit(c)) return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic int keyword_len(int k);
      return (k == 2) ? 5 : 4;
   endfunction

   function automatic logic [7:0] keyword_char(int k, int p);
      string s;
      s = (k == 1) ? "true" : (k == 2) ? "false" : "null";
      return (p < s.len()) ? s[p] : 8'h00;
   endfunction

   function automatic void lexer_reset();
      mode = MODE_IDLE;
      ofs = '0; cur_line = 20'd1; cur_col = 20'd1;
      tok_start = '0; tok_line = 20'd1; tok_col = 20'd1;
      int_acc = 0; frac_acc = 0; frac_cnt = 0; neg = 0;
      hexn = 0; kw = 0; esc = 0;
   endfunction

   function automatic void push_token(logic [4:0] kind, logic [23:0] start, logic [23:0] len,
                                      logic [19:0] line, logic [19:0] col, logic [39:0] num,
                                      logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a, logic [1:0] err);
      rsp_item_type t;
      t = '{kind, start, len, line, col, num, r, g, b, a, err, 1'b0};
      if (step_q.size() < MAX_RESULTS) step_q.push_back(t);
   endfunction

   function automatic void push_error(logic [23:0] start, logic [19:0] line,
                                      logic [19:0] col, logic [1:0] err);
      push_token(KIND_ERROR, start, 0, line, col, 0, 0, 0, 0, 0, err);
   endfunction

   function automatic void step_position(logic [7:0] c);
      ofs = ofs + 24'd1;
      if (c == 8'h0A) begin
         if (cur_line != LINE_SAT) cur_line = cur_line + 20'd1;
         cur_col = 20'd1;
      end else if (cur_col != LINE_SAT) begin
         cur_col = cur_col + 20'd1;
      end
   endfunction

   function automatic void mark_token();
      tok_start = ofs; tok_line = cur_line; tok_col = cur_col;
   endfunction

   function automatic void close_ident();
      logic [4:0]  kind;
      logic [23:0] len;
      len = ofs - tok_start;
      kind = KIND_IDENT;
      if (kw >= 1 && kw <= 3 && len == 24'(keyword_len(kw))) kind = 5'(kw + 1);
      push_token(kind, tok_start, len, tok_line, tok_col, 0, 0, 0, 0, 0, ERR_NONE);
   endfunction

   function automatic void close_number();
      longint unsigned f5, mag;
      f5 = 0;
      if (frac_cnt >= 1 && frac_cnt <= 5) f5 = frac_acc * (10 ** (5 - frac_cnt));
      mag = (int_acc << FRACTION_BITS) + (((f5 << FRACTION_BITS) + 50000) / 100000);
      if (mag > MAG_SAT) mag = MAG_SAT;
      if (neg) mag = 0 - mag;
      push_token(KIND_NUMBER, tok_start, ofs - tok_start, tok_line, tok_col, mag[39:0],
                 0, 0, 0, 0, ERR_NONE);
   endfunction

   function automatic void close_color();
      logic [7:0] r, g, b, a;
      a = 8'd255;
      if (hexn == 3 || hexn == 4) begin
         r = 8'(hexd[0] * 17); g = 8'(hexd[1] * 17); b = 8'(hexd[2] * 17);
         if (hexn == 4) a = 8'(hexd[3] * 17);
      end else if (hexn == 6 || hexn == 8) begin
         r = {hexd[0], hexd[1]}; g = {hexd[2], hexd[3]}; b = {hexd[4], hexd[5]};
         if (hexn == 8) a = {hexd[6], hexd[7]};
      end else begin
         push_error(tok_start, tok_line, tok_col, ERR_BAD_COLOR);
         return;
      end
      push_token(KIND_COLOR, tok_start, ofs - tok_start, tok_line, tok_col, 0, r, g, b, a,
                 ERR_NONE);
   endfunction

   function automatic void start_number(logic [7:0] c, bit minus);
      neg = minus; int_acc = c - "0"; frac_acc = 0; frac_cnt = 0;
      mode = MODE_INT;
   endfunction

   function automatic void between_tokens(logic [7:0] c);
      logic [4:0] punct;
      mode = MODE_IDLE;
      if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
         step_position(c);
         return;
      end
      mark_token();
      if (is_alpha(c)) begin
         kw = (c == "t") ? 1 : (c == "f") ? 2 : (c == "n") ? 3 : 0;
         step_position(c);
         mode = MODE_IDENT;
         return;
      end
      if (is_digit(c)) begin
         step_position(c);
         start_number(c, 0);
         return;
      end
      punct = KIND_EOF;
      case (c)
         "-": begin mode = MODE_MINUS; return; end
         "/": begin mode = MODE_SLASH; return; end
         "\"": begin
            step_position(c); tok_start = ofs; esc = 0; mode = MODE_STRING;
            return;
         end
         "#": begin step_position(c); hexn = 0; mode = MODE_COLOR; return; end
         "{": punct = KIND_LBRACE;
         "}": punct = KIND_RBRACE;
         "(": punct = KIND_LPAREN;
         ")": punct = KIND_RPAREN;
         ":": punct = KIND_COLON;
         ",": punct = KIND_COMMA;
         ".": punct = KIND_DOT;
         "%": punct = KIND_PERCENT;
         default: ;
      endcase
      if (punct != KIND_EOF)
         push_token(punct, tok_start, 1, tok_line, tok_col, 0, 0, 0, 0, 0, ERR_NONE);
      else
         push_error(tok_start, tok_line, tok_col, ERR_UNEXPECTED);
      step_position(c);
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      int hv;
      case (mode)
         MODE_IDENT: begin
            if (!(is_alpha(c) || is_digit(c) || c == "-")) begin
               close_ident(); between_tokens(c);
               return;
            end
            if (kw >= 1 && kw <= 3) begin
               if (!(int'(ofs - tok_start) < keyword_len(kw) &&
                     c == keyword_char(kw, int'(ofs - tok_start)))) kw = 0;
            end
            step_position(c);
         end
         MODE_INT: begin
            if (is_digit(c)) begin
               int_acc = int_acc * 10 + (c - "0");
               if (int_acc > INT_SAT) int_acc = INT_SAT;
               step_position(c);
            end else if (c == ".") begin
               mode = MODE_POINT;
            end else begin
               close_number(); between_tokens(c);
            end
         end
         MODE_POINT: begin
            if (is_digit(c)) begin
               step_position(".");
               frac_acc = c - "0"; frac_cnt = 1;
               step_position(c);
               mode = MODE_FRAC;
            end else begin
               close_number();
               push_token(KIND_DOT, ofs, 1, cur_line, cur_col, 0, 0, 0, 0, 0, ERR_NONE);
               step_position(".");
               between_tokens(c);
            end
         end
         MODE_FRAC: begin
            if (!is_digit(c)) begin
               close_number(); between_tokens(c);
               return;
            end
            if (frac_cnt < 5) begin
               frac_acc = frac_acc * 10 + (c - "0");
               frac_cnt++;
            end
            step_position(c);
         end
         MODE_STRING: begin
            if (esc) esc = 0;
            else if (c == "\"") begin
               push_token(KIND_STRING, tok_start, ofs - tok_start, tok_line, tok_col, 0,
                          0, 0, 0, 0, ERR_NONE);
               mode = MODE_IDLE;
            end else if (c == "\\") esc = 1;
            step_position(c);
         end
         MODE_COLOR: begin
            hv = hex_value(c);
            if (hv >= 0 && hexn < MAX_COLOR_DIGITS) begin
               hexd[hexn] = hv[3:0];
               hexn++;
               step_position(c);
            end else begin
               close_color(); between_tokens(c);
            end
         end
         MODE_LINE: begin
            if (c == 8'h0A) mode = MODE_IDLE;
            step_position(c);
         end
         MODE_BLOCK: begin
            if (c == "*") mode = MODE_STAR;
            step_position(c);
         end
         MODE_STAR: begin
            if (c == "/") mode = MODE_IDLE;
            else if (c != "*") mode = MODE_BLOCK;
            step_position(c);
         end
         MODE_SLASH: begin
            if (c == "/" || c == "*") begin
               step_position("/"); step_position(c);
               mode = (c == "/") ? MODE_LINE : MODE_BLOCK;
            end else begin
               push_error(ofs, cur_line, cur_col, ERR_UNEXPECTED);
               step_position("/");
               between_tokens(c);
            end
         end
         MODE_MINUS: begin
            if (is_digit(c)) begin
               mark_token();
               step_position("-"); step_position(c);
               start_number(c, 1);
            end else begin
               push_error(ofs, cur_line, cur_col, ERR_UNEXPECTED);
               step_position("-");
               between_tokens(c);
            end
         end
         default: between_tokens(c);
      endcase
   endfunction

   function automatic void lex_end();
      case (mode)
         MODE_IDENT: close_ident();
         MODE_INT, MODE_FRAC: close_number();
         MODE_POINT: begin
            close_number();
            push_token(KIND_DOT, ofs, 1, cur_line, cur_col, 0, 0, 0, 0, 0, ERR_NONE);
            step_position(".");
         end
         MODE_STRING: push_error(tok_start - 24'd1, tok_line, tok_col, ERR_UNTERMINATED);
         MODE_COLOR: close_color();
         MODE_SLASH, MODE_MINUS: begin
            push_error(ofs, cur_line, cur_col, ERR_UNEXPECTED);
            step_position("-");
         end
         default: ;
      endcase
      push_token(KIND_EOF, ofs, 0, cur_line, cur_col, 0, 0, 0, 0, 0, ERR_NONE);
      lexer_reset();
   endfunction

   function automatic void predict_tokens(src_item_type it);
      step_q.delete();
      if (it.op) lex_end();
      else lex_byte(it.ch);
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) token_q.push_back(step_q[i]);
   endfunction

   // Stimulus helpers.
   function automatic void add_text(string s);
      foreach (s[i]) source_q.push_back('{1'b0, s[i]});
   endfunction

   function automatic void add_end();
      source_q.push_back('{1'b1, 8'($urandom)});
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   function automatic void add_fragment();
      string alnum, hexs, sep;
      int n;
      alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789-";
      hexs = "0123456789abcdefABCDEFgx";
      sep = "  \n\t\r";
      case ($urandom_range(11))
         0, 1: begin
            source_q.push_back('{1'b0, pick(alnum.substr(0, 52))});
            n = $urandom_range(6);
            repeat (n) source_q.push_back('{1'b0, pick(alnum)});
         end
         2: begin
            case ($urandom_range(3))
               0: add_text("true");
               1: add_text("false");
               2: add_text("null");
               default: add_text("nul");
            endcase
         end
         3, 4: begin
            if ($urandom_range(1)) add_text("-");
            n = $urandom_range(1, 12);
            repeat (n) source_q.push_back('{1'b0, 8'("0" + $urandom_range(9))});
            if ($urandom_range(2) != 0) begin
               add_text(".");
               n = $urandom_range(7);
               repeat (n) source_q.push_back('{1'b0, 8'("0" + $urandom_range(9))});
            end
         end
         5: begin
            add_text("\"");
            n = $urandom_range(6);
            repeat (n) begin
               if ($urandom_range(4) == 0) add_text("\\");
               source_q.push_back('{1'b0, 8'($urandom)});
            end
            if ($urandom_range(5) != 0) add_text("\"");
         end
         6, 7: begin
            add_text("#");
            n = ($urandom_range(2) == 0) ? $urandom_range(9) : 3 + ($urandom_range(2) & 1) +
                (($urandom_range(1)) ? 3 : 0);
            repeat (n) source_q.push_back('{1'b0, pick(hexs.substr(0, 21))});
         end
         8: source_q.push_back('{1'b0, pick("{}():,.%/-")});
         9: begin
            if ($urandom_range(1)) add_text("// note\n");
            else add_text("/* x ** y */");
         end
         10: source_q.push_back('{1'b0, 8'($urandom)});
         default: if ($urandom_range(3) == 0) add_end();
      endcase
      if ($urandom_range(3) != 0) source_q.push_back('{1'b0, pick(sep)});
   endfunction

   // Driver.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (source_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid <= 1'b1;
            {req_bus.op, req_bus.source_byte} <= source_q.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with one long hold-off while the sender keeps going.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && n_sent >= 150) begin
         hold_done <= 1'b1;
         hold_cycles <= 80;
         rsp_bus.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predicts on accepted requests and checks accepted tokens.
   always @(posedge clock) begin
      rsp_item_type got, want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_tokens('{req_bus.op, req_bus.source_byte});
            n_sent <= n_sent + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.token_kind, rsp_bus.start_offset, rsp_bus.lexeme_length,
                    rsp_bus.line_number, rsp_bus.column_number, rsp_bus.number_value,
                    rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.alpha,
                    rsp_bus.error_kind, rsp_bus.last};
            if (token_q.size() == 0) begin
               unexpected_tokens++;
               if (mismatches + unexpected_tokens <= 10)
                  $display("unexpected token transaction %p", got);
            end else begin
               want = token_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches + unexpected_tokens <= 10)
                     $display("token mismatch:\n  expected %p\n  actual   %p", want, got);
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = 1'b0;
      req_bus.source_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      lexer_reset();
      for (int i = 0; i < 8; i++) hexd[i] = '0;

      add_text("ab-c true nul 12.5 -3.1415926 7. #fff #abcd #12345678 #12345 ");
      add_end();
      add_text("{}():,.%/x-y \"a\\\"b\" // c\n/* ** */ 99999999999 \"open\\");
      add_end();
      source_q.push_back('{1'b0, 8'h00});
      source_q.push_back('{1'b0, 8'hFF});
      add_text("#123456789 -");
      add_end();
      add_text("/");
      add_end();
      add_text("3.");
      add_end();
      while (source_q.size() < 220) add_fragment();
      add_end();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (n_sent >= 100);
      send_idle_pct = 88;
      recv_idle_pct = 28;
      wait (n_sent >= 140);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (source_q.size() > 0 || req_bus.valid || token_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && unexpected_tokens == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
`default_nettype wire
